// ===== rtl/slint_pkg.sv =====
// slint_pkg: shared constants, op codes and controller/datapath bundles
// for the sorted list intersection block. No dependencies.
package slint_pkg;

  localparam int DEPTH        = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MCNT_W       = $clog2(RESULT_LIMIT + 1);

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic flush;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic done;
    logic eq;
    logic hold_v;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/slint_ctrl.sv =====
// slint_ctrl: controller state machine for the merge walk.
// Depends on slint_pkg for op codes and the command/status structs.
module slint_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [slint_pkg::OP_W-1:0]  in_op,
  input  slint_pkg::dp_sts_t          sts,
  output slint_pkg::dp_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            slint_pkg::OP_LOAD_A: cmd.load_a = 1'b1;
            slint_pkg::OP_LOAD_B: cmd.load_b = 1'b1;
            slint_pkg::OP_START: begin
              cmd.start = 1'b1;
              state_nxt = S_WALK;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (sts.done) begin
          state_nxt = S_FLUSH;
        // a new match must push the held one out; wait for room
        end else if (!(sts.eq && sts.hold_v && !sts.out_free)) begin
          cmd.step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_step_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.done)
    else $error("walk step issued after the walk finished");

  a_start_walks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_WALK))
    else $error("start did not enter the walk");

endmodule

// ===== rtl/slint_dp.sv =====
// slint_dp: datapath with the two list stores, counts, walk indices,
// held match and output register. Depends on slint_pkg.
module slint_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  slint_pkg::dp_cmd_t                 cmd,
  output slint_pkg::dp_sts_t                 sts,
  input  logic signed [slint_pkg::DATA_W-1:0] in_elem_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [slint_pkg::DATA_W-1:0] out_common_value,
  output logic                               out_has_value,
  output logic                               out_last
);

  logic [slint_pkg::DATA_W-1:0] mem_a [slint_pkg::DEPTH];
  logic [slint_pkg::DATA_W-1:0] mem_b [slint_pkg::DEPTH];

  logic signed [slint_pkg::DATA_W-1:0] rd_a_r;
  logic signed [slint_pkg::DATA_W-1:0] rd_b_r;

  logic [slint_pkg::CNT_W-1:0]  cnt_a_r, cnt_a_nxt;
  logic [slint_pkg::CNT_W-1:0]  cnt_b_r, cnt_b_nxt;
  logic [slint_pkg::CNT_W-1:0]  ia_r, ia_nxt;
  logic [slint_pkg::CNT_W-1:0]  ib_r, ib_nxt;
  logic [slint_pkg::MCNT_W-1:0] mcnt_r, mcnt_nxt;

  logic signed [slint_pkg::DATA_W-1:0] hold_r, hold_nxt;
  logic                                hold_v_r, hold_v_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [slint_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic                                out_has_r, out_has_nxt;
  logic                                out_last_r, out_last_nxt;

  logic wr_a;
  logic wr_b;
  logic a_lt_b;
  logic b_lt_a;
  logic out_free;
  logic push_hold;

  assign wr_a     = cmd.load_a && (cnt_a_r < slint_pkg::CNT_W'(slint_pkg::DEPTH));
  assign wr_b     = cmd.load_b && (cnt_b_r < slint_pkg::CNT_W'(slint_pkg::DEPTH));
  assign a_lt_b   = rd_a_r < rd_b_r;
  assign b_lt_a   = rd_b_r < rd_a_r;
  assign out_free = !out_valid_r || out_ready;
  // a new match while one is held sends the held one out, not last
  assign push_hold = cmd.step && !a_lt_b && !b_lt_a && hold_v_r;

  assign sts.done = (ia_r >= cnt_a_r) || (ib_r >= cnt_b_r) ||
                    (mcnt_r == slint_pkg::MCNT_W'(slint_pkg::RESULT_LIMIT));
  assign sts.eq       = !a_lt_b && !b_lt_a;
  assign sts.hold_v   = hold_v_r;
  assign sts.out_free = out_free;

  always_comb begin
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    ia_nxt     = ia_r;
    ib_nxt     = ib_r;
    mcnt_nxt   = mcnt_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    if (wr_a) begin
      cnt_a_nxt = cnt_a_r + 1'b1;
    end
    if (wr_b) begin
      cnt_b_nxt = cnt_b_r + 1'b1;
    end
    if (cmd.start) begin
      ia_nxt     = '0;
      ib_nxt     = '0;
      mcnt_nxt   = '0;
      hold_v_nxt = 1'b0;
    end else if (cmd.step) begin
      if (a_lt_b) begin
        ia_nxt = ia_r + 1'b1;
      end else if (b_lt_a) begin
        ib_nxt = ib_r + 1'b1;
      end else begin
        ia_nxt     = ia_r + 1'b1;
        ib_nxt     = ib_r + 1'b1;
        mcnt_nxt   = mcnt_r + 1'b1;
        hold_nxt   = rd_a_r;
        hold_v_nxt = 1'b1;
      end
    end
    if (cmd.flush) begin
      cnt_a_nxt  = '0;
      cnt_b_nxt  = '0;
      hold_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push_hold) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = hold_r;
      out_has_nxt   = 1'b1;
      out_last_nxt  = 1'b0;
    end else if (cmd.flush) begin
      // final item: held match, or the empty marker
      out_valid_nxt = 1'b1;
      out_value_nxt = hold_v_r ? hold_r : '0;
      out_has_nxt   = hold_v_r;
      out_last_nxt  = 1'b1;
    end
  end

  // stores: read address follows the next index so data lines up with ia_r/ib_r
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[slint_pkg::IDX_W-1:0]] <= in_elem_value;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[slint_pkg::IDX_W-1:0]] <= in_elem_value;
    end
    rd_a_r <= mem_a[ia_nxt[slint_pkg::IDX_W-1:0]];
    rd_b_r <= mem_b[ib_nxt[slint_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      mcnt_r      <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      mcnt_r      <= mcnt_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r      <= hold_nxt;
    out_value_r <= out_value_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_common_value = out_value_r;
  assign out_has_value    = out_has_r;
  assign out_last         = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= slint_pkg::CNT_W'(slint_pkg::DEPTH)) &&
    (cnt_b_r <= slint_pkg::CNT_W'(slint_pkg::DEPTH)))
    else $error("list count beyond store depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_hold || cmd.flush) |-> out_free)
    else $error("item pushed over an untaken result");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (cnt_a_r == '0) && (cnt_b_r == '0) && !hold_v_r)
    else $error("counts not cleared after a run");

  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mcnt_r <= slint_pkg::MCNT_W'(slint_pkg::RESULT_LIMIT))
    else $error("match count beyond result limit");

endmodule

// ===== rtl/sorted_list_intersection_top.sv =====
// sorted_list_intersection_top: loads two ascending lists, then emits their
// merge-join intersection. A load item leaves in_ready high.
// Start item: one compare per cycle from the store read ports, except while an
// untaken result blocks the next one; in_ready stays low until the walk ends
// and the final item is pushed. One result per match, else one marker.
// Synchronous active-low reset clears counts, walk state and out_valid;
// store contents are undefined until loaded.
module sorted_list_intersection_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [slint_pkg::OP_W-1:0]          in_op,
  input  logic signed [slint_pkg::DATA_W-1:0] in_elem_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [slint_pkg::DATA_W-1:0] out_common_value,
  output logic                                out_has_value,
  output logic                                out_last
);

  slint_pkg::dp_cmd_t cmd;
  slint_pkg::dp_sts_t sts;

  slint_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  slint_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_elem_value    (in_elem_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_common_value (out_common_value),
    .out_has_value    (out_has_value),
    .out_last         (out_last)
  );

endmodule
